>>> hw/rtl/prd_pkg.sv
// Shared types and constants for the palette run-length decoder.
// Used by palette_rle_decoder and prd_palette. No dependencies.
package prd_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam logic [7:0] RUN_MARK = 8'hFF;

    // Color component selected by a palette write, in stream order.
    localparam logic [1:0] LANE_RED   = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_BLUE  = 2'd2;

    // One palette write: a single color component of one entry.
    typedef struct packed {
        logic       we;
        logic [1:0] lane;
        logic [7:0] addr;
        logic [7:0] data;
    } pal_wr_t;

endpackage

>>> hw/rtl/prd_palette.sv
// Palette store of the palette run-length decoder: one byte-wide memory per color
// component, one write and one registered read per cycle. Depends on prd_pkg.
module prd_palette #(
    parameter int PALETTE_DEPTH = prd_pkg::PALETTE_DEPTH_DEF
) (
    input  logic            aclk,
    input  prd_pkg::pal_wr_t wr,
    input  logic            rd_en,
    input  logic [7:0]      rd_addr,
    output logic [23:0]     rd_data
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;

    assign waddr = wr.addr[IDX_W-1:0];
    assign raddr = rd_addr[IDX_W-1:0];

    for (genvar c = 0; c < 3; c++) begin : g_lane
        logic [7:0] mem [PALETTE_DEPTH];
        logic [7:0] rd_reg;
        logic       lane_we;

        assign lane_we = wr.we && (wr.lane == 2'(c));

        always_ff @(posedge aclk) begin
            if (lane_we) begin
                mem[waddr] <= wr.data;
            end
            // A same-edge write to the read address is passed straight through.
            if (rd_en) begin
                if (lane_we && (waddr == raddr)) begin
                    rd_reg <= wr.data;
                end else begin
                    rd_reg <= mem[raddr];
                end
            end
        end
    end

    assign rd_data = {g_lane[prd_pkg::LANE_RED].rd_reg,
                      g_lane[prd_pkg::LANE_GREEN].rd_reg,
                      g_lane[prd_pkg::LANE_BLUE].rd_reg};

endmodule

>>> hw/rtl/palette_rle_decoder.sv
// Top level of the indexed-color run-length decoder: byte parser and result register.
// Depends on prd_pkg and prd_palette.
//
// The decoder takes one byte per clock while its results are taken and gives at most
// one result per byte. A byte is held in an input register while the palette is read
// at its value; the parser step and the color choice then go into the output register,
// from which the result word is presented on the master side. With the output taken
// every cycle the decoder sustains one byte per cycle; the palette memory has one
// write port and one read port. A stalled result word holds the output register, and
// the input side stops once the input register is also full.
// The palette is not cleared: after reset an entry holds a color only once the palette
// part of a stream has written it.
module palette_rle_decoder #(
    parameter int PALETTE_DEPTH = prd_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // red, green, blue, repeat_res, image_width, image_height
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // bad_index, truncated
    output logic        m_tlast    // end_of_image
);

    localparam logic [2:0] PH_HEADER      = 3'd0;
    localparam logic [2:0] PH_PALETTE     = 3'd1;
    localparam logic [2:0] PH_INDEX       = 3'd2;
    localparam logic [2:0] PH_AFTER_INDEX = 3'd3;
    localparam logic [2:0] PH_COUNT       = 3'd4;

    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state.
    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  hpos_reg, hpos_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  ccount_reg, ccount_next;
    logic [7:0]  entry_reg, entry_next;
    logic [1:0]  comp_reg, comp_next;
    logic [23:0] hold_rgb_reg, hold_rgb_next;
    logic        hold_bad_reg, hold_bad_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg;
    logic [1:0]  out_user_reg;
    logic        out_last_reg;

    logic             adv;
    logic             fire;
    logic             s_accept;
    logic [23:0]      pal_rd;
    prd_pkg::pal_wr_t pal_wr;

    logic        have;
    logic [23:0] rgb;
    logic [7:0]  rep;
    logic        bad;
    logic        trunc;
    logic        idx_bad;

    assign adv      = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;
    assign s_accept = s_tvalid && s_tready;

    prd_palette #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr      (pal_wr),
        .rd_en   (s_accept),
        .rd_addr (s_tdata),
        .rd_data (pal_rd)
    );

    assign idx_bad = (in_byte_reg >= ccount_reg) || ({1'b0, in_byte_reg} >= DEPTH_LIM);

    always_comb begin
        phase_next    = phase_reg;
        hpos_next     = hpos_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        ccount_next   = ccount_reg;
        entry_next    = entry_reg;
        comp_next     = comp_reg;
        hold_rgb_next = hold_rgb_reg;
        hold_bad_next = hold_bad_reg;
        have          = 1'b0;
        rgb           = '0;
        rep           = '0;
        bad           = 1'b0;
        trunc         = 1'b0;
        pal_wr.we     = 1'b0;
        pal_wr.lane   = comp_reg;
        pal_wr.addr   = entry_reg;
        pal_wr.data   = in_byte_reg;

        case (phase_reg)
            PH_HEADER: begin
                case (hpos_reg)
                    3'd0: width_next[15:8]  = in_byte_reg;
                    3'd1: width_next[7:0]   = in_byte_reg;
                    3'd2: height_next[15:8] = in_byte_reg;
                    3'd3: height_next[7:0]  = in_byte_reg;
                    default: begin
                        ccount_next = in_byte_reg;
                        entry_next  = '0;
                        comp_next   = prd_pkg::LANE_RED;
                        phase_next  = (in_byte_reg != 8'd0) ? PH_PALETTE : PH_INDEX;
                    end
                endcase
                hpos_next = hpos_reg + 3'd1;
            end
            PH_PALETTE: begin
                // Entries past the store are consumed and dropped.
                pal_wr.we = fire && ({1'b0, entry_reg} < DEPTH_LIM);
                if (comp_reg == prd_pkg::LANE_BLUE) begin
                    comp_next  = prd_pkg::LANE_RED;
                    entry_next = entry_reg + 8'd1;
                    if (entry_next == ccount_reg) begin
                        phase_next = PH_INDEX;
                    end
                end else begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            PH_INDEX, PH_AFTER_INDEX: begin
                if (phase_reg == PH_AFTER_INDEX && in_byte_reg == prd_pkg::RUN_MARK) begin
                    phase_next = PH_COUNT;
                    trunc      = in_last_reg;
                end else begin
                    bad           = idx_bad;
                    rgb           = idx_bad ? 24'd0 : pal_rd;
                    rep           = 8'd1;
                    have          = 1'b1;
                    hold_rgb_next = rgb;
                    hold_bad_next = bad;
                    phase_next    = PH_AFTER_INDEX;
                end
            end
            PH_COUNT: begin
                if (in_byte_reg != 8'd0) begin
                    rgb  = hold_rgb_reg;
                    bad  = hold_bad_reg;
                    rep  = in_byte_reg;
                    have = 1'b1;
                end
                phase_next = PH_INDEX;
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        // The final byte always gives a result; without a pixel it is a bare end marker.
        if (in_last_reg && !have) begin
            have = 1'b1;
            rgb  = '0;
            rep  = '0;
            bad  = 1'b0;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = fire && have;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hpos_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            ccount_reg <= '0;
            entry_reg  <= '0;
            comp_reg   <= prd_pkg::LANE_RED;
        end else if (fire) begin
            if (in_last_reg) begin
                phase_reg  <= PH_HEADER;
                hpos_reg   <= '0;
                width_reg  <= '0;
                height_reg <= '0;
                ccount_reg <= '0;
                entry_reg  <= '0;
                comp_reg   <= prd_pkg::LANE_RED;
            end else begin
                phase_reg  <= phase_next;
                hpos_reg   <= hpos_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                ccount_reg <= ccount_next;
                entry_reg  <= entry_next;
                comp_reg   <= comp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire) begin
            hold_rgb_reg <= hold_rgb_next;
            hold_bad_reg <= hold_bad_next;
        end
        if (adv) begin
            out_data_reg <= {height_next, width_next, rep, rgb[7:0], rgb[15:8], rgb[23:16]};
            out_user_reg <= {trunc, bad};
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> hw/rtl/prd_checker.sv
// Port-level checks for palette_rle_decoder, attached to it by the bind below.
// Depends only on the top level's ports.
module prd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result word holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result word changed");

    // A truncated run is only reported on the end-of-image word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("truncated flag outside end of image");

    // Only an end marker carries a repeat count of zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[31:24] != 8'd0)
        else $error("zero repeat count on a pixel word");

    // A bad index always decodes to black.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[23:0] == 24'd0)
        else $error("bad index word is not black");

endmodule

bind palette_rle_decoder prd_checker u_prd_checker (.*);
